/* design/swrpm_pkg.sv */
// Shared types, widths and register indexes for the SWR and RF power meter.
// Used by the top level, the shared restoring divider and the bench.
package swrpm_pkg;

   localparam int REM_W  = 46;
   localparam int QUO_W  = 16;
   localparam int STEP_W = 5;

   localparam logic [2:0] CSR_CORRECTION = 3'd0;
   localparam logic [2:0] CSR_GAIN       = 3'd1;
   localparam logic [2:0] CSR_HIGH_POWER = 3'd2;
   localparam logic [2:0] CSR_POWER_MIN  = 3'd3;
   localparam logic [2:0] CSR_POWER_MAX  = 3'd4;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [REM_W-1:0]  num;
      logic [REM_W-1:0]  den_sh;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_sts_type;

endpackage

/* design/swrpm_divider.sv */
// Shared restoring divider: one quotient bit per cycle.
// Depends on swrpm_pkg for the command and status structs.
module swrpm_divider
   import swrpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);

   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  dsh_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic              fit_in;
   logic [REM_W-1:0]  diff_in;

   assign fit_in  = rem_ff >= dsh_ff;
   assign diff_in = rem_ff - dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !cmd.start && busy_ff && (cnt_ff == STEP_W'(1));
         if (cmd.start) begin
            rem_ff  <= cmd.num;
            dsh_ff  <= cmd.den_sh;
            quo_ff  <= '0;
            cnt_ff  <= cmd.steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fit_in) begin
               rem_ff <= diff_in;
            end
            quo_ff <= {quo_ff[QUO_W-2:0], fit_in};
            dsh_ff <= {1'b0, dsh_ff[REM_W-1:1]};
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

/* design/swr_power_meter.sv */
// A transfer in carries forward and reverse detector levels; each gives one result transfer
// with SWR x100, rounded power, window peak, overload and in-window flags. Work is done by
// one shared multiplier and one restoring divider that yields one quotient bit per cycle:
// 16 steps for power, 11 for SWR. The SWR division is skipped when reverse is not below
// forward. The input stalls while an item is in work.
// Depends on swrpm_pkg and swrpm_divider.
module swr_power_meter
   import swrpm_pkg::*;
#(
   parameter int PEAK_WINDOW = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_forward_level,
   input  logic [11:0] req_reverse_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_swr_times_100,
   output logic [14:0] rsp_power_value,
   output logic [14:0] rsp_peak_power,
   output logic        rsp_overload,
   output logic        rsp_power_in_window,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   localparam int CNT_W = $clog2(PEAK_WINDOW + 1);

   localparam logic [26:0] DEN_HIGH    = 27'd99969800;
   localparam logic [26:0] DEN_LOW     = 27'd9996980;
   localparam logic [9:0]  SWR_INVALID = 10'd999;
   localparam logic [14:0] POWER_SAT   = 15'h7FFF;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_MUL_CK, S_MUL_SQ, S_DIV_P, S_WAIT_P,
      S_MUL_S, S_DIV_S, S_WAIT_S, S_DONE
   } state_type;

   function automatic logic [13:0] diode_offset(input logic [13:0] c);
      logic [13:0] r;
      if (c <= 14'd80)         r = 14'd0;
      else if (c <= 14'd171)   r = c + 14'd244;
      else if (c <= 14'd328)   r = c + 14'd254;
      else if (c <= 14'd582)   r = c + 14'd280;
      else if (c <= 14'd820)   r = c + 14'd297;
      else if (c <= 14'd1100)  r = c + 14'd310;
      else if (c <= 14'd2181)  r = c + 14'd430;
      else if (c <= 14'd3322)  r = c + 14'd484;
      else if (c <= 14'd4623)  r = c + 14'd530;
      else if (c <= 14'd5862)  r = c + 14'd648;
      else if (c <= 14'd7146)  r = c + 14'd743;
      else if (c <= 14'd8502)  r = c + 14'd800;
      else if (c <= 14'd10500) r = c + 14'd840;
      else                     r = c + 14'd860;
      return r;
   endfunction

   state_type        state_ff;
   logic             corr_ff;
   logic [7:0]       gain_ff;
   logic             high_ff;
   logic [14:0]      pmin_ff;
   logic [14:0]      pmax_ff;
   logic [11:0]      fwd_ff;
   logic [11:0]      rev_ff;
   logic [13:0]      c_ff;
   logic [43:0]      prod_ff;
   logic [14:0]      pwr_ff;
   logic [9:0]       swr_ff;
   logic [CNT_W-1:0] win_cnt_ff;
   logic [14:0]      peak_ff;
   logic             rsp_valid_ff;
   logic [9:0]       rsp_swr_ff;
   logic [14:0]      rsp_pwr_ff;
   logic [14:0]      rsp_peak_ff;
   logic             rsp_ovl_ff;
   logic             rsp_win_ff;

   logic [13:0]      c3_in;
   logic [13:0]      c_in;
   logic [21:0]      mul_a;
   logic [21:0]      mul_b;
   logic [43:0]      prod_in;
   logic [12:0]      sum_fr;
   logic [11:0]      diff_fr;
   logic [26:0]      den;
   logic [10:0]      swr_q;
   logic [14:0]      peak_in;
   logic [CNT_W-1:0] win_cnt_in;
   logic             in_win_in;
   div_cmd_type      div_cmd;
   div_sts_type      div_sts;

   assign c3_in   = {2'b00, fwd_ff} + {1'b0, fwd_ff, 1'b0};
   assign c_in    = corr_ff ? diode_offset(c3_in) : c3_in;
   assign sum_fr  = {1'b0, fwd_ff} + {1'b0, rev_ff};
   assign diff_fr = fwd_ff - rev_ff;
   assign den     = high_ff ? DEN_HIGH : DEN_LOW;
   assign swr_q   = div_sts.quotient[10:0];
   assign prod_in = mul_a * mul_b;

   always_comb begin
      case (state_ff)
         S_MUL_CK: begin
            mul_a = {8'd0, c_ff};
            mul_b = {14'd0, gain_ff};
         end
         S_MUL_SQ: begin
            mul_a = prod_ff[21:0];
            mul_b = prod_ff[21:0];
         end
         S_MUL_S: begin
            mul_a = {9'd0, sum_fr};
            mul_b = 22'd100;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_cmd.start  = 1'b0;
      div_cmd.steps  = STEP_W'(16);
      div_cmd.num    = {1'b0, prod_ff, 1'b0} + {19'd0, den};
      div_cmd.den_sh = {3'd0, den, 1'b0, 15'd0};
      case (state_ff)
         S_DIV_P: begin
            div_cmd.start = 1'b1;
         end
         S_DIV_S: begin
            div_cmd.start  = 1'b1;
            div_cmd.steps  = STEP_W'(11);
            div_cmd.num    = {26'd0, prod_ff[19:0]};
            div_cmd.den_sh = {24'd0, diff_fr, 10'd0};
         end
         default: begin
            div_cmd.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (win_cnt_ff == CNT_W'(PEAK_WINDOW)) begin
         win_cnt_in = '0;
         peak_in    = '0;
      end else begin
         win_cnt_in = win_cnt_ff + CNT_W'(1);
         peak_in    = (pwr_ff > peak_ff) ? pwr_ff : peak_ff;
      end
      in_win_in = (pwr_ff >= pmin_ff) && !((pmax_ff != 15'd0) && (pwr_ff > pmax_ff));
   end

   swrpm_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         corr_ff      <= 1'b0;
         gain_ff      <= 8'd100;
         high_ff      <= 1'b0;
         pmin_ff      <= '0;
         pmax_ff      <= '0;
         win_cnt_ff   <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CORRECTION: corr_ff <= csr_wdata[0];
               CSR_GAIN:       gain_ff <= csr_wdata[7:0];
               CSR_HIGH_POWER: high_ff <= csr_wdata[0];
               CSR_POWER_MIN:  pmin_ff <= csr_wdata;
               CSR_POWER_MAX:  pmax_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  fwd_ff   <= req_forward_level;
                  rev_ff   <= req_reverse_level;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               c_ff     <= c_in;
               state_ff <= S_MUL_CK;
            end
            S_MUL_CK: begin
               prod_ff  <= prod_in;
               state_ff <= S_MUL_SQ;
            end
            S_MUL_SQ: begin
               prod_ff  <= prod_in;
               state_ff <= S_DIV_P;
            end
            S_DIV_P: begin
               state_ff <= S_WAIT_P;
            end
            S_WAIT_P: begin
               if (div_sts.done) begin
                  pwr_ff   <= div_sts.quotient[15] ? POWER_SAT : div_sts.quotient[14:0];
                  state_ff <= S_MUL_S;
               end
            end
            S_MUL_S: begin
               prod_ff <= prod_in;
               if (rev_ff >= fwd_ff) begin
                  swr_ff   <= SWR_INVALID;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DIV_S;
               end
            end
            S_DIV_S: begin
               state_ff <= S_WAIT_S;
            end
            S_WAIT_S: begin
               if (div_sts.done) begin
                  if ((swr_q > 11'd999) || (swr_q < 11'd100)) begin
                     swr_ff <= SWR_INVALID;
                  end else begin
                     swr_ff <= swr_q[9:0];
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_swr_ff   <= swr_ff;
                  rsp_pwr_ff   <= pwr_ff;
                  rsp_peak_ff  <= peak_in;
                  rsp_ovl_ff   <= fwd_ff > 12'd4000;
                  rsp_win_ff   <= in_win_in;
                  win_cnt_ff   <= win_cnt_in;
                  peak_ff      <= peak_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall           = state_ff != S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_swr_times_100   = rsp_swr_ff;
   assign rsp_power_value     = rsp_pwr_ff;
   assign rsp_peak_power      = rsp_peak_ff;
   assign rsp_overload        = rsp_ovl_ff;
   assign rsp_power_in_window = rsp_win_ff;

endmodule

/* design/swrpm_checker.sv */
// Port-level checks for swr_power_meter, attached by the bind at the end of this file.
// Depends only on the top level's ports.
module swrpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_swr_times_100,
   input logic [14:0] rsp_power_value,
   input logic [14:0] rsp_peak_power
);

   // A transfer in starts a multi-cycle computation, so the input is busy next cycle.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after a transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_power_value)
         && $stable(rsp_swr_times_100) && $stable(rsp_peak_power))
      else $error("stalled result changed");

   a_swr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_swr_times_100 >= 10'd100) && (rsp_swr_times_100 <= 10'd999))
      else $error("SWR out of range");

   // The peak is either restarted at zero or covers this sample's power.
   a_peak_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peak_power >= rsp_power_value) || (rsp_peak_power == 15'd0))
      else $error("peak below current power");

endmodule

bind swr_power_meter swrpm_checker u_swrpm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_swr_times_100 (rsp_swr_times_100),
   .rsp_power_value   (rsp_power_value),
   .rsp_peak_power    (rsp_peak_power)
);

/* bench/swr_power_meter_tb.sv */
// Self-checking bench for swr_power_meter: random and directed level pairs, with checks
// of every result transfer against a predictor held in a small scoreboard class.
// Depends on swrpm_pkg, swrpm_divider and swr_power_meter from the design folder.
module swr_power_meter_tb
   import swrpm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PEAK_WINDOW     = 100;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int PHASES          = 10;
   localparam int SETTLE_CYCLES   = 64;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int IDLE_PERCENT    = 32;

   localparam int         CSR_COUNT      = 5;

   localparam int unsigned SWR_INVALID  = 999;
   localparam int unsigned OVERLOAD_MV  = 4000;
   localparam int unsigned POWER_MAX    = 32767;
   localparam longint unsigned SQRT2_SQ = 1999396;

   typedef struct packed {
      logic [9:0]  swr;
      logic [14:0] power;
      logic [14:0] peak;
      logic        overload;
      logic        in_window;
   } meter_reading_type;

   class meter_scoreboard;
      logic        corr_en;
      logic [7:0]  gain;
      logic        high_mode;
      logic [14:0] pmin;
      logic [14:0] pmax;
      logic [6:0]  window_count;
      logic [14:0] peak_hold;
      meter_reading_type expected_readings[$];
      int errors;
      int transfers_in;
      int results_checked;
      int window_restarts;

      function new();
         corr_en = 1'b0;
         gain = 8'd100;
         high_mode = 1'b0;
         pmin = '0;
         pmax = '0;
         window_count = '0;
         peak_hold = '0;
         errors = 0;
         transfers_in = 0;
         results_checked = 0;
         window_restarts = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [14:0] value);
         case (index)
            CSR_CORRECTION: corr_en = value[0];
            CSR_GAIN:       gain = value[7:0];
            CSR_HIGH_POWER: high_mode = value[0];
            CSR_POWER_MIN:  pmin = value;
            CSR_POWER_MAX:  pmax = value;
            default: ;
         endcase
      endfunction

      function int unsigned corrected_level(int unsigned c);
         if (c <= 80) return 0;
         if (c <= 171) return c + 244;
         if (c <= 328) return c + 254;
         if (c <= 582) return c + 280;
         if (c <= 820) return c + 297;
         if (c <= 1100) return c + 310;
         if (c <= 2181) return c + 430;
         if (c <= 3322) return c + 484;
         if (c <= 4623) return c + 530;
         if (c <= 5862) return c + 648;
         if (c <= 7146) return c + 743;
         if (c <= 8502) return c + 800;
         if (c <= 10500) return c + 840;
         return c + 860;
      endfunction

      function logic [14:0] power_for(logic [11:0] fwd);
         longint unsigned c, v, num, den;
         c = longint'(fwd) * 3;
         if (corr_en) c = corrected_level(int'(c));
         v = c * longint'(gain);
         num = v * v;
         den = SQRT2_SQ * (high_mode ? 50 : 5);
         v = (2 * num + den) / (2 * den);
         if (v > POWER_MAX) v = POWER_MAX;
         return 15'(v);
      endfunction

      function logic [9:0] swr_for(logic [11:0] fwd, logic [11:0] rev);
         int unsigned f, r, s;
         f = fwd;
         r = rev;
         if (r >= f) return 10'(SWR_INVALID);
         s = ((f + r) * 100) / (f - r);
         if (s > SWR_INVALID) s = SWR_INVALID;
         if (s < 100) s = SWR_INVALID;
         return 10'(s);
      endfunction

      function void note_transfer(logic [11:0] fwd, logic [11:0] rev);
         meter_reading_type want;
         want.power = power_for(fwd);
         if (window_count != PEAK_WINDOW) begin
            window_count = window_count + 7'd1;
            if (want.power > peak_hold) peak_hold = want.power;
         end else begin
            window_count = '0;
            peak_hold = '0;
            window_restarts++;
         end
         want.swr = swr_for(fwd, rev);
         want.peak = peak_hold;
         want.overload = (fwd > OVERLOAD_MV);
         want.in_window = (want.power >= pmin) && !(pmax != 0 && want.power > pmax);
         expected_readings.push_back(want);
         transfers_in++;
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic [9:0] swr, logic [14:0] power, logic [14:0] peak,
                        logic overload, logic in_window);
         meter_reading_type want;
         if (expected_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected result swr %0d power %0d", swr, power));
            return;
         end
         want = expected_readings.pop_front();
         results_checked++;
         if (swr !== want.swr)
            report_mismatch($sformatf("swr %0d, expected %0d", swr, want.swr));
         if (power !== want.power)
            report_mismatch($sformatf("power %0d, expected %0d", power, want.power));
         if (peak !== want.peak)
            report_mismatch($sformatf("peak %0d, expected %0d", peak, want.peak));
         if (overload !== want.overload)
            report_mismatch($sformatf("overload %b, expected %b", overload, want.overload));
         if (in_window !== want.in_window)
            report_mismatch($sformatf("in window %b, expected %b", in_window, want.in_window));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [11:0] req_forward_level = '0;
   logic [11:0] req_reverse_level = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [9:0]  rsp_swr_times_100;
   logic [14:0] rsp_power_value;
   logic [14:0] rsp_peak_power;
   logic        rsp_overload;
   logic        rsp_power_in_window;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [14:0] csr_wdata = '0;

   logic quiet = 1'b0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   stuck_cycles = 0;
   int   settings_applied = 0;
   meter_scoreboard sb;

   swr_power_meter #(.PEAK_WINDOW(PEAK_WINDOW)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_forward_level(req_forward_level),
      .req_reverse_level(req_reverse_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_swr_times_100(rsp_swr_times_100),
      .rsp_power_value(rsp_power_value),
      .rsp_peak_power(rsp_peak_power),
      .rsp_overload(rsp_overload),
      .rsp_power_in_window(rsp_power_in_window),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_swr_times_100, rsp_power_value, rsp_peak_power,
                         rsp_overload, rsp_power_in_window);
      end
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
                  WATCHDOG_LIMIT, sb.pending());
         $display("** swr_power_meter: FAILED **");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic send_levels(input logic [11:0] fwd, input logic [11:0] rev);
      while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_forward_level <= fwd;
      req_reverse_level <= rev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_transfer(fwd, rev);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic corr, input logic [7:0] gain, input logic high,
                                 input logic [14:0] pmin, input logic [14:0] pmax);
      logic [14:0] raw [CSR_COUNT];
      int i;
      raw[CSR_CORRECTION] = {14'($urandom), corr};
      raw[CSR_GAIN]       = {7'($urandom), gain};
      raw[CSR_HIGH_POWER] = {14'($urandom), high};
      raw[CSR_POWER_MIN]  = pmin;
      raw[CSR_POWER_MAX]  = pmax;
      for (i = 0; i < CSR_COUNT; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= raw[i];
         sb.set_register(3'(i), raw[i]);
         @(posedge clock);
      end
      // An index past the last register must leave every setting alone.
      csr_index <= CSR_POWER_MAX + 3'($urandom_range(1, 3));
      csr_wdata <= 15'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_applied++;
   endtask

   initial begin
      int phase, n, pmin_pick, pmax_pick;
      logic [11:0] f, r;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_levels(12'd0, 12'd0);
      send_levels(12'd4095, 12'd4095);
      send_levels(12'd4095, 12'd0);
      send_levels(12'd4092, 12'd0);
      send_levels(12'd4001, 12'd10);
      send_levels(12'd4000, 12'd10);
      send_levels(12'd1000, 12'd0);
      send_levels(12'd100, 12'd99);
      send_levels(12'd100, 12'd100);
      send_levels(12'd50, 12'd200);
      send_levels(12'd300, 12'd100);
      send_levels(12'd2000, 12'd1);
      send_levels(12'd1, 12'd0);
      send_levels(12'hAAA, 12'h555);
      send_levels(12'h555, 12'h2AA);
      wait_idle();

      apply_settings(1'b1, 8'd30, 1'b0, 15'd10, 15'd500);
      send_levels(12'd26, 12'd0);
      send_levels(12'd27, 12'd3);
      send_levels(12'd57, 12'd20);
      send_levels(12'd58, 12'd57);
      send_levels(12'd367, 12'd0);
      send_levels(12'd1365, 12'd400);
      send_levels(12'd3500, 12'd3499);
      send_levels(12'd3501, 12'd0);
      send_levels(12'd4095, 12'd1);
      wait_idle();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: apply_settings(1'b1, 8'd255, 1'b1, 15'd0, 15'd0);
            1: apply_settings(1'b0, 8'd0, 1'b0, 15'd0, 15'h7FFF);
            2: apply_settings(1'b1, 8'd1, 1'b0, 15'h7FFF, 15'd0);
            default: begin
               pmin_pick = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3000);
               pmax_pick = ($urandom_range(0, 2) == 0) ? 0 :
                           pmin_pick + $urandom_range(0, 20000);
               if (pmax_pick > POWER_MAX) pmax_pick = POWER_MAX;
               apply_settings(1'($urandom), 8'($urandom_range(20, 255)), 1'($urandom),
                              15'(pmin_pick), 15'(pmax_pick));
            end
         endcase
         if (phase == 3) hold_toggle <= ~hold_toggle;
         quiet <= (phase == 4);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            f = 12'($urandom);
            case ($urandom_range(0, 9))
               0: r = 12'($urandom);
               1, 2: begin
                  f = 12'($urandom_range(0, 400));
                  r = 12'($urandom_range(0, f));
               end
               3: r = 12'($urandom_range(f, 4095));
               4: r = (f == 0) ? 12'd0 : f - 12'd1;
               default: r = 12'($urandom_range(0, f));
            endcase
            send_levels(f, r);
         end
         wait_idle();
      end

      $display("Covered %0d transfers in and %0d results over %0d register settings,",
               sb.transfers_in, sb.results_checked, settings_applied);
      $display("with %0d peak window restarts, a %0d-cycle output hold and an idle-free stretch.",
               sb.window_restarts, HOLD_CYCLES);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** swr_power_meter: PASSED **");
      end else begin
         $display("** swr_power_meter: FAILED **");
      end
      $finish;
   end

endmodule
